@@ rtl/core/blid_pkg.sv @@
// Shared types, constants and codes for the bounded list block.
package blid_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int OP_W         = 2;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic start;
    logic shift_rd;
    logic shift_wr;
    logic shift_end;
    logic dump;
  } cmd_t;

  typedef struct packed {
    logic del_go;
    logic shift_more;
    logic dump_done;
  } stat_t;

endpackage

@@ rtl/core/blid_if.sv @@
// Valid/ready channel interfaces for list operations and dumped entries.
interface blid_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [blid_pkg::OP_W-1:0]            operation;
  logic signed [blid_pkg::DATA_W-1:0]   value;
  logic [blid_pkg::POS_W-1:0]           position;

  modport source (output valid, output operation, output value, output position, input ready);
  modport sink   (input valid, input operation, input value, input position, output ready);
endinterface

interface blid_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [blid_pkg::DATA_W-1:0]   element;
  logic                                 last;
  logic                                 list_empty;
  logic                                 insert_refused;

  modport source (output valid, output element, output last, output list_empty,
                  output insert_refused, input ready);
  modport sink   (input valid, input element, input last, input list_empty,
                  input insert_refused, output ready);
endinterface

@@ rtl/core/bounded_list_insert_delete_dump.sv @@
// Top level of the bounded ordered list with a full dump after every operation.
// An insert or ignored operation goes straight from acceptance to the dump phase.
// A delete at position P first shifts the N - P later entries down, N being those held after it.
// Dump items pass the store read register and then the output register, one a cycle unless stalled.
// Store reads with registered data set the shift cost; a new item waits for the last dump item.
// Reset clears the pointers, count and control state; the entry store itself is not cleared.
module bounded_list_insert_delete_dump #(
  parameter int CAPACITY = blid_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  blid_in_if.sink     in_ch,
  blid_out_if.source  out_ch
);

  blid_pkg::cmd_t  cmd;
  blid_pkg::stat_t stat;

  blid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  blid_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .operation      (in_ch.operation),
    .value          (in_ch.value),
    .position       (in_ch.position),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .element        (out_ch.element),
    .last           (out_ch.last),
    .list_empty     (out_ch.list_empty),
    .insert_refused (out_ch.insert_refused)
  );

endmodule

@@ rtl/core/blid_ctrl.sv @@
// Controller state machine that sequences accept, shift and dump phases.
module blid_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  blid_pkg::stat_t stat,
  output blid_pkg::cmd_t  cmd
);

  blid_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blid_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      blid_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = stat.del_go ? blid_pkg::ST_SHIFT_RD : blid_pkg::ST_DUMP;
        end
      end
      blid_pkg::ST_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_next   = blid_pkg::ST_SHIFT_WR;
        end else begin
          cmd.shift_end = 1'b1;
          state_next    = blid_pkg::ST_DUMP;
        end
      end
      blid_pkg::ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = blid_pkg::ST_SHIFT_RD;
      end
      blid_pkg::ST_DUMP: begin
        cmd.dump = 1'b1;
        if (stat.dump_done) begin
          state_next = blid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = blid_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/blid_datapath.sv @@
// Datapath with the circular entry store, list pointers and output register.
module blid_datapath #(
  parameter int CAPACITY = blid_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  blid_pkg::cmd_t                      cmd,
  output blid_pkg::stat_t                     stat,
  input  logic [blid_pkg::OP_W-1:0]           operation,
  input  logic signed [blid_pkg::DATA_W-1:0]  value,
  input  logic [blid_pkg::POS_W-1:0]          position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [blid_pkg::DATA_W-1:0]  element,
  output logic                                last,
  output logic                                list_empty,
  output logic                                insert_refused
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam int PW = (CW > blid_pkg::POS_W) ? CW : blid_pkg::POS_W;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [SW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + off;
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  logic [blid_pkg::DATA_W-1:0] mem [CAPACITY];
  logic [blid_pkg::DATA_W-1:0] rdata;

  logic [AW-1:0] front;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          rd_pend;
  logic          rd_last;
  logic          refused;

  logic                        full;
  logic                        empty;
  logic                        is_ins;
  logic [AW-1:0]               front_dec;
  logic                        out_free;
  logic                        load;
  logic                        load_empty;
  logic                        issue;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [blid_pkg::DATA_W-1:0] wdata;
  logic                        re;
  logic [AW-1:0]               raddr;

  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign is_ins    = (operation == blid_pkg::OP_INS_FRONT) ||
                     (operation == blid_pkg::OP_INS_BACK);
  assign front_dec = (front == '0) ? AW'(CAPACITY - 1) : front - 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign load       = cmd.dump && !empty && rd_pend && out_free;
  assign load_empty = cmd.dump && empty && out_free;
  assign issue      = cmd.dump && !empty && (idx < count) && (!rd_pend || load);

  assign stat.del_go     = (operation == blid_pkg::OP_DELETE) &&
                           (PW'(position) < PW'(count));
  assign stat.shift_more = (SW'(idx) + SW'(1)) < SW'(count);
  assign stat.dump_done  = load_empty || (load && rd_last);

  always_comb begin
    we    = 1'b0;
    waddr = front;
    wdata = rdata;
    if (cmd.start && is_ins && !full) begin
      we    = 1'b1;
      wdata = value;
      waddr = (operation == blid_pkg::OP_INS_FRONT) ? front_dec : slot_of(front, SW'(count));
    end else if (cmd.shift_wr) begin
      we    = 1'b1;
      waddr = slot_of(front, SW'(idx));
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = slot_of(front, SW'(idx));
    if (cmd.shift_rd) begin
      re    = 1'b1;
      raddr = slot_of(front, SW'(idx) + SW'(1));
    end else if (issue) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      idx       <= '0;
      rd_pend   <= 1'b0;
      rd_last   <= 1'b0;
      refused   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        refused <= is_ins && full;
        rd_pend <= 1'b0;
        idx     <= stat.del_go ? CW'(position) : '0;
        if (is_ins && !full) begin
          count <= count + 1'b1;
          if (operation == blid_pkg::OP_INS_FRONT) begin
            front <= front_dec;
          end
        end
      end
      if (cmd.shift_wr) begin
        idx <= idx + 1'b1;
      end
      if (cmd.shift_end) begin
        count <= count - 1'b1;
        idx   <= '0;
      end
      if (issue) begin
        idx     <= idx + 1'b1;
        rd_last <= (SW'(idx) + SW'(1)) == SW'(count);
        rd_pend <= 1'b1;
      end else if (load) begin
        rd_pend <= 1'b0;
      end
      if (load || load_empty) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      element        <= rdata;
      last           <= rd_last;
      list_empty     <= 1'b0;
      insert_refused <= refused;
    end else if (load_empty) begin
      element        <= '0;
      last           <= 1'b1;
      list_empty     <= 1'b1;
      insert_refused <= refused;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> $past(cmd.shift_rd))
    else $error("shift write without a preceding read");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && list_empty) |-> last)
    else $error("empty item not marked last");

  a_pend_held: assert property (@(posedge clk) disable iff (rst)
    (cmd.dump && rd_pend && !load) |=> rd_pend)
    else $error("pending read data dropped before loading");

endmodule

@@ verif/list_dump_checker.sv @@
// Checker for the bounded list: predicts every dump item from accepted operations and compares.
module list_dump_checker #(
  parameter int CAPACITY = blid_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  blid_in_if   in_ch,
  blid_out_if  out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [blid_pkg::DATA_W-1:0] element;
    logic                               last;
    logic                               list_empty;
    logic                               insert_refused;
  } dump_item_t;

  logic signed [blid_pkg::DATA_W-1:0] shadow_entries [CAPACITY];
  int                                 shadow_front = 0;
  int                                 shadow_count = 0;
  dump_item_t                         expected_dump [$];
  int                                 mismatch_count = 0;

  function automatic int slot_of(int offset);
    return (shadow_front + offset) % CAPACITY;
  endfunction

  function automatic void apply_operation(logic [blid_pkg::OP_W-1:0] op,
                                          logic signed [blid_pkg::DATA_W-1:0] val,
                                          logic [blid_pkg::POS_W-1:0] pos);
    logic       refused;
    dump_item_t item;
    int         i;
    refused = 1'b0;
    if (op == blid_pkg::OP_INS_FRONT || op == blid_pkg::OP_INS_BACK) begin
      if (shadow_count >= CAPACITY) begin
        refused = 1'b1;
      end else if (op == blid_pkg::OP_INS_FRONT) begin
        shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
        shadow_entries[shadow_front] = val;
        shadow_count++;
      end else begin
        shadow_entries[slot_of(shadow_count)] = val;
        shadow_count++;
      end
    end else if (op == blid_pkg::OP_DELETE) begin
      if (int'(pos) < shadow_count) begin
        for (i = int'(pos); i + 1 < shadow_count; i++) begin
          shadow_entries[slot_of(i)] = shadow_entries[slot_of(i + 1)];
        end
        shadow_count--;
      end
    end
    if (shadow_count == 0) begin
      item.element        = '0;
      item.last           = 1'b1;
      item.list_empty     = 1'b1;
      item.insert_refused = refused;
      expected_dump.push_back(item);
    end else begin
      for (i = 0; i < shadow_count; i++) begin
        item.element        = shadow_entries[slot_of(i)];
        item.last           = (i + 1 == shadow_count);
        item.list_empty     = 1'b0;
        item.insert_refused = refused;
        expected_dump.push_back(item);
      end
    end
  endfunction

  function automatic void report_mismatch(string what, dump_item_t want, dump_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t mismatch (%s): expected element %0d last %0b empty %0b refused %0b,",
               $realtime, what, want.element, want.last, want.list_empty,
               want.insert_refused);
      $display("    got element %0d last %0b empty %0b refused %0b",
               got.element, got.last, got.list_empty, got.insert_refused);
    end
  endfunction

  always @(posedge clk) begin
    dump_item_t got;
    dump_item_t want;
    if (rst) begin
      shadow_front = 0;
      shadow_count = 0;
      expected_dump.delete();
      fail_count <= mismatch_count;
      pending    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_operation(in_ch.operation, in_ch.value, in_ch.position);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.element        = out_ch.element;
        got.last           = out_ch.last;
        got.list_empty     = out_ch.list_empty;
        got.insert_refused = out_ch.insert_refused;
        if (expected_dump.size() == 0) begin
          want = '0;
          report_mismatch("unexpected item", want, got);
        end else begin
          want = expected_dump.pop_front();
          if (got.element !== want.element || got.last !== want.last ||
              got.list_empty !== want.list_empty ||
              got.insert_refused !== want.insert_refused) begin
            report_mismatch("wrong field", want, got);
          end
        end
      end
      fail_count <= mismatch_count;
      pending    <= expected_dump.size();
    end
  end

endmodule

@@ verif/bounded_list_insert_delete_dump_tb.sv @@
// Top of the bounded list testbench: clock, reset, operation stimulus, output stalls and verdict.
module bounded_list_insert_delete_dump_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                        CAPACITY     = blid_pkg::CAPACITY_DEF;
  localparam int                        RANDOM_ITEMS = 270;
  localparam int                        CYCLE_LIMIT  = 1_000_000;
  localparam int                        DRAIN_CYCLES = 2 * CAPACITY + 40;
  localparam logic [blid_pkg::OP_W-1:0] OP_UNUSED    = 2'd3;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  logic clk = 1'b0;
  logic rst;
  logic calm = 1'b0;
  int   fail_count;
  int   pending;
  int   list_len;
  int   cycle_count;

  blid_in_if  in_ch ();
  blid_out_if out_ch ();

  bounded_list_insert_delete_dump #(.CAPACITY(CAPACITY)) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_dump_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  task automatic send_op(input logic [blid_pkg::OP_W-1:0] op,
                         input logic signed [blid_pkg::DATA_W-1:0] val,
                         input logic [blid_pkg::POS_W-1:0] pos);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= val;
    in_ch.position  <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == blid_pkg::OP_INS_FRONT || op == blid_pkg::OP_INS_BACK) begin
      if (list_len < CAPACITY) list_len++;
    end else if (op == blid_pkg::OP_DELETE) begin
      if (int'(pos) < list_len) list_len--;
    end
  endtask

  function automatic logic [blid_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_operation(input phase_t kind, input bit inserts_only);
    int                          r;
    int                          ins_weight;
    logic [blid_pkg::OP_W-1:0]   op;
    logic [blid_pkg::POS_W-1:0]  pos;
    r = $urandom_range(0, 99);
    case (kind)
      PH_FILL:  ins_weight = 85;
      PH_DRAIN: ins_weight = 20;
      default:  ins_weight = 45;
    endcase
    if (inserts_only || r < ins_weight) begin
      op = $urandom_range(0, 1) ? blid_pkg::OP_INS_BACK : blid_pkg::OP_INS_FRONT;
    end else if (kind == PH_MIXED && r >= 95) begin
      op = OP_UNUSED;
    end else begin
      op = blid_pkg::OP_DELETE;
    end
    if (list_len > 0 && $urandom_range(0, 9) < 8) begin
      pos = blid_pkg::POS_W'($urandom_range(0, list_len - 1));
    end else begin
      pos = blid_pkg::POS_W'($urandom_range(0, 63));
    end
    send_op(op, random_value(), pos);
  endtask

  initial begin
    forever begin
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int     items_left;
    int     phase_len;
    int     k;
    bit     first_phase;
    phase_t kind;
    list_len         = 0;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= blid_pkg::OP_INS_FRONT;
    in_ch.value     <= '0;
    in_ch.position  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_op(blid_pkg::OP_DELETE,    32'sd0,        6'd0);
    send_op(OP_UNUSED,              32'sd0,        6'd0);
    send_op(blid_pkg::OP_INS_FRONT, 32'h8000_0000, 6'd63);
    send_op(blid_pkg::OP_INS_BACK,  32'h7FFF_FFFF, 6'd0);
    send_op(blid_pkg::OP_INS_FRONT, 32'hFFFF_FFFF, 6'd0);
    send_op(blid_pkg::OP_INS_BACK,  32'h0000_0000, 6'd0);
    send_op(OP_UNUSED,              32'hFFFF_FFFF, 6'd63);
    send_op(blid_pkg::OP_DELETE,    32'sd0,        6'd63);
    send_op(blid_pkg::OP_DELETE,    32'sd0,        6'd4);
    send_op(blid_pkg::OP_DELETE,    32'sd0,        6'd3);
    send_op(blid_pkg::OP_DELETE,    32'sd0,        6'd0);
    send_op(blid_pkg::OP_INS_BACK,  32'h5555_5555, 6'd0);
    send_op(blid_pkg::OP_INS_FRONT, 32'hAAAA_AAAA, 6'd0);
    send_op(blid_pkg::OP_DELETE,    32'sd0,        6'd1);
    send_op(blid_pkg::OP_DELETE,    32'sd0,        6'd0);
    send_op(blid_pkg::OP_DELETE,    32'sd0,        6'd0);
    send_op(blid_pkg::OP_DELETE,    32'sd0,        6'd0);
    send_op(blid_pkg::OP_DELETE,    32'sd0,        6'd0);

    items_left  = RANDOM_ITEMS;
    first_phase = 1'b1;
    while (items_left > 0) begin
      if (first_phase) begin
        phase_len = CAPACITY + 8;
        kind      = PH_FILL;
        calm      = 1'b0;
      end else begin
        phase_len = $urandom_range(10, 40);
        kind      = phase_t'($urandom_range(0, 2));
        calm      = ($urandom_range(0, 3) == 0);
      end
      for (k = 0; k < phase_len && items_left > 0; k++) begin
        random_operation(kind, first_phase);
        items_left--;
      end
      first_phase = 1'b0;
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
